// ----- hdl/hafu_pkg.sv -----
// Shared types, codes and defaults of the handle allocator with flag table.
`default_nettype none
package hafu_pkg;

	localparam int DEF_CAPACITY = 256;

	// Operation codes.
	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_DESTROY = 3'd1;
	localparam logic [2:0] OP_ADD     = 3'd2;
	localparam logic [2:0] OP_REMOVE  = 3'd3;
	localparam logic [2:0] OP_HAS     = 3'd4;
	localparam logic [2:0] OP_ALIVE   = 3'd5;

	// Status codes.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] entity_id;
		logic [31:0] component_flags;
	} req_t;

	typedef struct packed {
		logic [7:0] result_id;
		logic       answer;
		logic [1:0] status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic exec;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/hafu_ctrl.sv -----
// Controller state machine of the handle allocator: clearing pass, accept, read, execute.
`default_nettype none
module hafu_ctrl
	import hafu_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look  = 1'b1;
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				// The item commits only once the result register can take it.
				if (sts.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hafu_dpath.sv -----
// Datapath of the handle allocator: flag table, free id queue, pointers and result register.
`default_nettype none
module hafu_dpath
	import hafu_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire  clk,
	input  wire  arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	localparam int ID_W  = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [31:0] flag_mem [CAPACITY];
	logic [ID_W-1:0] queue_mem [CAPACITY];

	logic [2:0]      op_q;
	logic [15:0]     id_q;
	logic [31:0]     flags_q;
	logic [31:0]     flag_rd_q;
	logic [ID_W-1:0] queue_rd_q;
	logic [ID_W-1:0] head_q;
	logic [ID_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] fresh_q;
	logic [ID_W-1:0] clr_q;
	logic            out_valid_q;
	rsp_t            out_q;

	logic            in_range;
	logic [ID_W-1:0] id_idx;
	logic            have_free;
	logic            got;
	logic [ID_W-1:0] nid;
	logic [15:0]     nid_ext;
	logic            q_full;
	logic            flag_we;
	logic [ID_W-1:0] flag_wa;
	logic [31:0]     flag_wd;
	logic            queue_we;
	logic            take_free;
	logic            take_fresh;
	rsp_t            res;

	assign in_range  = {1'b0, id_q} < 17'(CAPACITY);
	assign id_idx    = id_q[ID_W-1:0];
	assign have_free = (count_q != '0);
	assign got       = have_free || (fresh_q != CNT_W'(CAPACITY));
	assign nid       = have_free ? queue_rd_q : fresh_q[ID_W-1:0];
	assign nid_ext   = 16'(nid);
	assign q_full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		flag_we    = 1'b0;
		flag_wa    = id_idx;
		flag_wd    = '0;
		queue_we   = 1'b0;
		take_free  = 1'b0;
		take_fresh = 1'b0;
		res.result_id = id_q[7:0];
		res.answer    = 1'b0;
		res.status    = STS_OK;
		if (cmd.clear) begin
			flag_we = 1'b1;
			flag_wa = clr_q;
		end else if (op_q == OP_CREATE) begin
			if (got) begin
				flag_we       = cmd.exec;
				flag_wa       = nid;
				take_free     = cmd.exec && have_free;
				take_fresh    = cmd.exec && !have_free;
				res.result_id = nid_ext[7:0];
			end else begin
				res.result_id = '0;
				res.status    = STS_EMPTY;
			end
		end else if (op_q == OP_DESTROY || op_q == OP_ADD || op_q == OP_REMOVE
				|| op_q == OP_HAS || op_q == OP_ALIVE) begin
			if (!in_range) begin
				res.status = STS_RANGE;
			end else begin
				case (op_q)
					OP_DESTROY: begin
						flag_we = cmd.exec;
						if (q_full) begin
							res.status = STS_FULL;
						end else begin
							queue_we = cmd.exec;
						end
					end
					OP_ADD: begin
						flag_we = cmd.exec;
						flag_wd = flag_rd_q | flags_q;
					end
					OP_REMOVE: begin
						flag_we = cmd.exec;
						flag_wd = flag_rd_q & ~flags_q;
					end
					OP_HAS: begin
						res.answer = ((flag_rd_q & flags_q) == flags_q);
					end
					OP_ALIVE: begin
						res.answer = (flag_rd_q != '0);
					end
					default: begin
						res.answer = 1'b0;
					end
				endcase
			end
		end
	end

	// Memories: one write port each, registered reads issued in the look cycle.
	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (cmd.look) begin
			flag_rd_q <= flag_mem[id_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (queue_we) begin
			queue_mem[tail_q] <= id_idx;
		end
		if (cmd.look) begin
			queue_rd_q <= queue_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req.opcode;
			id_q    <= req.entity_id;
			flags_q <= req.component_flags;
		end
		if (cmd.exec) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= ID_W'(clr_q + 1'b1);
			end
			if (take_free) begin
				head_q  <= (head_q == ID_W'(CAPACITY - 1)) ? '0 : ID_W'(head_q + 1'b1);
				count_q <= CNT_W'(count_q - 1'b1);
			end
			if (take_fresh) begin
				fresh_q <= CNT_W'(fresh_q + 1'b1);
			end
			if (queue_we) begin
				tail_q  <= (tail_q == ID_W'(CAPACITY - 1)) ? '0 : ID_W'(tail_q + 1'b1);
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = (clr_q == ID_W'(CAPACITY - 1));
	assign sts.out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid    = out_valid_q;
	assign rsp          = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("free queue count exceeds capacity");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CNT_W'(CAPACITY))
		else $error("fresh id counter exceeds capacity");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (count_q == '0 || count_q == CNT_W'(CAPACITY)))
		else $error("free queue pointers disagree with count");

	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed item did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |-> !cmd.exec)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- hdl/handle_allocator_with_flag_table_unit.sv -----
// Handle allocator with a per-id 32-bit flag table: each request beat (create, destroy,
// add, remove, has, alive) yields one response beat. After reset the block runs a clearing
// pass over all CAPACITY entries of the flag table, one entry per cycle, with req_stall high.
// An item then passes through accept, table and queue read, and execute with write-back,
// steps set by the registered read of the flag table and the free queue; a new request is
// taken only once the previous item has executed. A response waits in an output register,
// and the next request is accepted and read while it waits; created ids come first from the
// queue of destroyed ids, oldest first, and otherwise from a fresh counter.
`default_nettype none
module handle_allocator_with_flag_table_unit
	import hafu_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	hafu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hafu_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
